// ----- src/mma_pkg.sv -----
`default_nettype none

package mma_pkg;

   // width of every sample and level field on the ports
   localparam int unsigned FIELD_W = 12;

   // one adc scan
   typedef struct packed {
      logic               conversion_ok;
      logic [FIELD_W-1:0] battery_sample;
      logic [FIELD_W-1:0] pressure_sample;
      logic [FIELD_W-1:0] pump_current_sample;
      logic [FIELD_W-1:0] pump_voltage_sample;
   } req_type;

   // filtered levels and window status for one scan
   typedef struct packed {
      logic [FIELD_W-1:0] battery_level;
      logic [FIELD_W-1:0] pressure_level;
      logic [FIELD_W-1:0] pump_current_level;
      logic [FIELD_W-1:0] pump_voltage_level;
      logic               main_window_full;
      logic               pressure_window_full;
      logic               main_just_filled;
   } rsp_type;

endpackage

`default_nettype wire

// ----- src/multichannel_moving_average_top.sv -----
`default_nettype none

// Moving-average filter for four adc channels. Battery, pump current and pump voltage share
// one ring window of MAIN_DEPTH entries; pressure has its own ring of PRESS_DEPTH entries.
// Each ring is a synchronous memory with a registered read, paired with a running sum per
// channel. Until a window has filled once, its levels give the latest sample; after that
// they give the running sum divided by the depth, truncated, the division being a single
// multiply by a fixed reciprocal. A scan with conversion_ok low leaves the state alone but
// still produces a result. Every accepted scan yields exactly one result transfer. A scan
// occupies the ring port for a read of the oldest entry and then a write-back at the same
// index, so no new scan is accepted during the write-back; the result passes through the
// read, sum, multiply and output registers. No clearing pass is needed after reset.
module multichannel_moving_average_top
   import mma_pkg::*;
#(
   parameter int unsigned MAIN_DEPTH  = 32,
   parameter int unsigned PRESS_DEPTH = 64,
   parameter int unsigned SAMPLE_BITS = 12
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_stall,
   input  wire req_type req_data,
   output logic         rsp_valid,
   input  wire logic    rsp_stall,
   output rsp_type      rsp_data
);

   // stored sample width: samples are masked to SAMPLE_BITS, fields carry FIELD_W
   localparam int unsigned SW = (SAMPLE_BITS < FIELD_W) ? SAMPLE_BITS : FIELD_W;

   localparam int unsigned MAIN_IDX_W  = $clog2(MAIN_DEPTH);
   localparam int unsigned PRESS_IDX_W = $clog2(PRESS_DEPTH);
   localparam int unsigned MAIN_SUM_W  = SW + MAIN_IDX_W;
   localparam int unsigned PRESS_SUM_W = SW + PRESS_IDX_W;
   localparam int unsigned MAIN_SHIFT  = MAIN_SUM_W + MAIN_IDX_W;
   localparam int unsigned PRESS_SHIFT = PRESS_SUM_W + PRESS_IDX_W;
   localparam int unsigned MAIN_PROD_W  = 2 * MAIN_SUM_W + 1;
   localparam int unsigned PRESS_PROD_W = 2 * PRESS_SUM_W + 1;

   // reciprocals ceil(2^shift / depth): exact floor division for every sum that fits
   localparam logic [63:0] MAIN_RECIP_WIDE =
      ((64'd1 << MAIN_SHIFT) + 64'(MAIN_DEPTH) - 64'd1) / 64'(MAIN_DEPTH);
   localparam logic [63:0] PRESS_RECIP_WIDE =
      ((64'd1 << PRESS_SHIFT) + 64'(PRESS_DEPTH) - 64'd1) / 64'(PRESS_DEPTH);
   localparam logic [MAIN_SUM_W:0]  MAIN_RECIP  = MAIN_RECIP_WIDE[MAIN_SUM_W:0];
   localparam logic [PRESS_SUM_W:0] PRESS_RECIP = PRESS_RECIP_WIDE[PRESS_SUM_W:0];

   localparam logic [MAIN_IDX_W-1:0]  MAIN_LAST  = MAIN_IDX_W'(MAIN_DEPTH - 1);
   localparam logic [PRESS_IDX_W-1:0] PRESS_LAST = PRESS_IDX_W'(PRESS_DEPTH - 1);

   // ring memories
   logic [3*SW-1:0] main_ring_ff  [MAIN_DEPTH];
   logic [SW-1:0]   press_ring_ff [PRESS_DEPTH];
   logic [3*SW-1:0] main_rd_ff;
   logic [SW-1:0]   press_rd_ff;

   // pipeline control
   logic    rd_pend_ff, rd_pend_in;
   logic    sn_vld_ff, sn_vld_in;
   logic    mv_ff, mv_in;
   logic    rsp_valid_ff, rsp_valid_in;
   logic    req_acc, upd, mul_adv, mul_free, out_adv, out_free;
   req_type item_ff;

   // filter state
   logic [MAIN_SUM_W-1:0]  bat_sum_ff, bat_sum_in;
   logic [MAIN_SUM_W-1:0]  cur_sum_ff, cur_sum_in;
   logic [MAIN_SUM_W-1:0]  vol_sum_ff, vol_sum_in;
   logic [PRESS_SUM_W-1:0] prs_sum_ff, prs_sum_in;
   logic [MAIN_IDX_W-1:0]  main_idx_ff, main_idx_in;
   logic [PRESS_IDX_W-1:0] press_idx_ff, press_idx_in;
   logic                   main_full_ff, main_full_in;
   logic                   press_full_ff, press_full_in;
   logic                   pulse_ff, pulse_in;
   logic [SW-1:0]          lat_bat_ff, lat_prs_ff, lat_cur_ff, lat_vol_ff;

   // multiply stage
   logic [MAIN_PROD_W-1:0]  prod_bat_ff, prod_cur_ff, prod_vol_ff;
   logic [PRESS_PROD_W-1:0] prod_prs_ff;
   logic                    mv_main_full_ff, mv_press_full_ff, mv_pulse_ff;
   logic [SW-1:0]           mv_bat_ff, mv_prs_ff, mv_cur_ff, mv_vol_ff;

   rsp_type rsp_data_ff, rsp_data_in;

   logic [SW-1:0] bat_new, prs_new, cur_new, vol_new;
   logic [SW-1:0] bat_old, prs_old, cur_old, vol_old;
   logic          main_wrap, press_wrap;

   // handshake and stage advance
   always_comb begin
      out_free  = !rsp_valid_ff || !rsp_stall;
      out_adv   = mv_ff && out_free;
      mul_free  = !mv_ff || out_free;
      mul_adv   = sn_vld_ff && mul_free;
      req_stall = rd_pend_ff || (sn_vld_ff && !mul_free);
      req_acc   = req_valid && !req_stall;
      upd       = rd_pend_ff && item_ff.conversion_ok;

      rd_pend_in   = req_acc;
      sn_vld_in    = rd_pend_ff || (sn_vld_ff && !mul_free);
      mv_in        = mul_adv || (mv_ff && !out_free);
      rsp_valid_in = out_adv || (rsp_valid_ff && rsp_stall);
   end

   // read-modify-write of the running sums and ring indices
   always_comb begin
      bat_new = item_ff.battery_sample[SW-1:0];
      prs_new = item_ff.pressure_sample[SW-1:0];
      cur_new = item_ff.pump_current_sample[SW-1:0];
      vol_new = item_ff.pump_voltage_sample[SW-1:0];

      // the oldest entry only leaves the sum once the window has filled
      bat_old = main_full_ff  ? main_rd_ff[3*SW-1 -: SW] : '0;
      cur_old = main_full_ff  ? main_rd_ff[2*SW-1 -: SW] : '0;
      vol_old = main_full_ff  ? main_rd_ff[SW-1:0]       : '0;
      prs_old = press_full_ff ? press_rd_ff              : '0;

      main_wrap  = main_idx_ff == MAIN_LAST;
      press_wrap = press_idx_ff == PRESS_LAST;

      bat_sum_in    = bat_sum_ff;
      cur_sum_in    = cur_sum_ff;
      vol_sum_in    = vol_sum_ff;
      prs_sum_in    = prs_sum_ff;
      main_idx_in   = main_idx_ff;
      press_idx_in  = press_idx_ff;
      main_full_in  = main_full_ff;
      press_full_in = press_full_ff;
      pulse_in      = pulse_ff;

      if (rd_pend_ff) begin
         pulse_in = upd && main_wrap && !main_full_ff;
      end
      if (upd) begin
         bat_sum_in    = bat_sum_ff - MAIN_SUM_W'(bat_old) + MAIN_SUM_W'(bat_new);
         cur_sum_in    = cur_sum_ff - MAIN_SUM_W'(cur_old) + MAIN_SUM_W'(cur_new);
         vol_sum_in    = vol_sum_ff - MAIN_SUM_W'(vol_old) + MAIN_SUM_W'(vol_new);
         prs_sum_in    = prs_sum_ff - PRESS_SUM_W'(prs_old) + PRESS_SUM_W'(prs_new);
         main_idx_in   = main_wrap  ? '0 : main_idx_ff + 1'b1;
         press_idx_in  = press_wrap ? '0 : press_idx_ff + 1'b1;
         main_full_in  = main_full_ff || main_wrap;
         press_full_in = press_full_ff || press_wrap;
      end
   end

   // control and state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         rd_pend_ff    <= 1'b0;
         sn_vld_ff     <= 1'b0;
         mv_ff         <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         bat_sum_ff    <= '0;
         cur_sum_ff    <= '0;
         vol_sum_ff    <= '0;
         prs_sum_ff    <= '0;
         main_idx_ff   <= '0;
         press_idx_ff  <= '0;
         main_full_ff  <= 1'b0;
         press_full_ff <= 1'b0;
         pulse_ff      <= 1'b0;
         lat_bat_ff    <= '0;
         lat_prs_ff    <= '0;
         lat_cur_ff    <= '0;
         lat_vol_ff    <= '0;
      end else begin
         rd_pend_ff    <= rd_pend_in;
         sn_vld_ff     <= sn_vld_in;
         mv_ff         <= mv_in;
         rsp_valid_ff  <= rsp_valid_in;
         bat_sum_ff    <= bat_sum_in;
         cur_sum_ff    <= cur_sum_in;
         vol_sum_ff    <= vol_sum_in;
         prs_sum_ff    <= prs_sum_in;
         main_idx_ff   <= main_idx_in;
         press_idx_ff  <= press_idx_in;
         main_full_ff  <= main_full_in;
         press_full_ff <= press_full_in;
         pulse_ff      <= pulse_in;
         if (upd) begin
            lat_bat_ff <= bat_new;
            lat_prs_ff <= prs_new;
            lat_cur_ff <= cur_new;
            lat_vol_ff <= vol_new;
         end
      end
   end

   // ring memories: read the oldest entry on acceptance, write back in the cycle after when conversion_ok is set
   always_ff @(posedge clock) begin
      if (req_acc) begin
         item_ff     <= req_data;
         main_rd_ff  <= main_ring_ff[main_idx_ff];
         press_rd_ff <= press_ring_ff[press_idx_ff];
      end
      if (upd) begin
         main_ring_ff[main_idx_ff]   <= {bat_new, cur_new, vol_new};
         press_ring_ff[press_idx_ff] <= prs_new;
      end
   end

   // sum times reciprocal, with a snapshot of the status that goes with it
   always_ff @(posedge clock) begin
      if (mul_adv) begin
         prod_bat_ff      <= MAIN_PROD_W'(bat_sum_ff) * MAIN_PROD_W'(MAIN_RECIP);
         prod_cur_ff      <= MAIN_PROD_W'(cur_sum_ff) * MAIN_PROD_W'(MAIN_RECIP);
         prod_vol_ff      <= MAIN_PROD_W'(vol_sum_ff) * MAIN_PROD_W'(MAIN_RECIP);
         prod_prs_ff      <= PRESS_PROD_W'(prs_sum_ff) * PRESS_PROD_W'(PRESS_RECIP);
         mv_main_full_ff  <= main_full_ff;
         mv_press_full_ff <= press_full_ff;
         mv_pulse_ff      <= pulse_ff;
         mv_bat_ff        <= lat_bat_ff;
         mv_prs_ff        <= lat_prs_ff;
         mv_cur_ff        <= lat_cur_ff;
         mv_vol_ff        <= lat_vol_ff;
      end
   end

   // level select into the output register
   always_comb begin
      rsp_data_in.battery_level = FIELD_W'(mv_main_full_ff ?
         prod_bat_ff[MAIN_SHIFT +: SW] : mv_bat_ff);
      rsp_data_in.pump_current_level = FIELD_W'(mv_main_full_ff ?
         prod_cur_ff[MAIN_SHIFT +: SW] : mv_cur_ff);
      rsp_data_in.pump_voltage_level = FIELD_W'(mv_main_full_ff ?
         prod_vol_ff[MAIN_SHIFT +: SW] : mv_vol_ff);
      rsp_data_in.pressure_level = FIELD_W'(mv_press_full_ff ?
         prod_prs_ff[PRESS_SHIFT +: SW] : mv_prs_ff);
      rsp_data_in.main_window_full     = mv_main_full_ff;
      rsp_data_in.pressure_window_full = mv_press_full_ff;
      rsp_data_in.main_just_filled     = mv_pulse_ff;
   end

   always_ff @(posedge clock) begin
      if (out_adv) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef SYNTHESIS
   a_main_idx_range: assert property (@(posedge clock) disable iff (reset)
      main_idx_ff <= MAIN_LAST)
      else $error("main ring index beyond depth");

   a_main_full_sticky: assert property (@(posedge clock) disable iff (reset)
      main_full_ff |=> main_full_ff)
      else $error("main window full flag dropped");

   a_pulse_when_full: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff.main_just_filled |-> rsp_data_ff.main_window_full)
      else $error("fill pulse without a full main window");

   a_one_update_stage: assert property (@(posedge clock) disable iff (reset)
      !(rd_pend_ff && sn_vld_ff))
      else $error("two scans in the update stages at once");

   a_ring_idle_after_update: assert property (@(posedge clock) disable iff (reset)
      rd_pend_ff |=> !rd_pend_ff)
      else $error("ring write-back overlapped by a new read");
`endif

endmodule

`default_nettype wire

// ----- bench/tb_multichannel_moving_average_top.sv -----
`default_nettype none

module tb_multichannel_moving_average_top;
   import mma_pkg::*;

   localparam int unsigned MAIN_DEPTH   = 32;
   localparam int unsigned PRESS_DEPTH  = 64;
   localparam int unsigned RANDOM_SCANS = 790;
   localparam int unsigned STUCK_LIMIT  = 3000;
   localparam int unsigned DRAIN_CYCLES = 20;
   localparam int unsigned IDLE_PCT     = 18;
   localparam int unsigned QUIET_FIRST  = 400;
   localparam int unsigned QUIET_LAST   = 560;
   localparam int unsigned BACKLOG_AT   = 250;
   localparam int unsigned BACKLOG_LEN  = 200;
   localparam int unsigned SAMPLE_MAX   = (32'd1 << FIELD_W) - 32'd1;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   multichannel_moving_average_top #(
      .MAIN_DEPTH  (MAIN_DEPTH),
      .PRESS_DEPTH (PRESS_DEPTH),
      .SAMPLE_BITS (FIELD_W)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always #2 clock = ~clock;

   // scans waiting to be offered, and filter outputs still owed by the block
   req_type scan_queue[$];
   rsp_type owed_levels[$];
   int unsigned fail_count = 0;

   // filter state mirrored from the block
   logic [FIELD_W-1:0] battery_ring[MAIN_DEPTH];
   logic [FIELD_W-1:0] current_ring[MAIN_DEPTH];
   logic [FIELD_W-1:0] voltage_ring[MAIN_DEPTH];
   logic [FIELD_W-1:0] pressure_ring[PRESS_DEPTH];
   logic [16:0] battery_total  = '0;
   logic [16:0] current_total  = '0;
   logic [16:0] voltage_total  = '0;
   logic [17:0] pressure_total = '0;
   int unsigned main_slot      = 0;
   int unsigned pressure_slot  = 0;
   bit main_full     = 1'b0;
   bit pressure_full = 1'b0;
   logic [FIELD_W-1:0] last_battery  = '0;
   logic [FIELD_W-1:0] last_pressure = '0;
   logic [FIELD_W-1:0] last_current  = '0;
   logic [FIELD_W-1:0] last_voltage  = '0;

   // take one scan into the mirrored windows and return the levels it yields
   function automatic rsp_type filter_scan(input req_type scan);
      rsp_type levels;
      levels = '0;
      if (scan.conversion_ok) begin
         last_battery  = scan.battery_sample;
         last_pressure = scan.pressure_sample;
         last_current  = scan.pump_current_sample;
         last_voltage  = scan.pump_voltage_sample;

         // shared window: drop the oldest entry once full, then store the new one
         if (main_full) begin
            battery_total -= 17'(battery_ring[main_slot]);
            current_total -= 17'(current_ring[main_slot]);
            voltage_total -= 17'(voltage_ring[main_slot]);
         end
         battery_ring[main_slot] = scan.battery_sample;
         current_ring[main_slot] = scan.pump_current_sample;
         voltage_ring[main_slot] = scan.pump_voltage_sample;
         battery_total += 17'(scan.battery_sample);
         current_total += 17'(scan.pump_current_sample);
         voltage_total += 17'(scan.pump_voltage_sample);
         main_slot++;
         if (main_slot == MAIN_DEPTH) begin
            main_slot = 0;
            if (!main_full) begin
               main_full = 1'b1;
               levels.main_just_filled = 1'b1;
            end
         end

         // pressure window
         if (pressure_full)
            pressure_total -= 18'(pressure_ring[pressure_slot]);
         pressure_ring[pressure_slot] = scan.pressure_sample;
         pressure_total += 18'(scan.pressure_sample);
         pressure_slot++;
         if (pressure_slot == PRESS_DEPTH) begin
            pressure_slot = 0;
            pressure_full = 1'b1;
         end
      end

      // averages once a window has filled, latest samples before that
      if (main_full) begin
         levels.battery_level      = FIELD_W'(battery_total / MAIN_DEPTH);
         levels.pump_current_level = FIELD_W'(current_total / MAIN_DEPTH);
         levels.pump_voltage_level = FIELD_W'(voltage_total / MAIN_DEPTH);
      end else begin
         levels.battery_level      = last_battery;
         levels.pump_current_level = last_current;
         levels.pump_voltage_level = last_voltage;
      end
      levels.pressure_level = pressure_full ? FIELD_W'(pressure_total / PRESS_DEPTH)
                                            : last_pressure;
      levels.main_window_full     = main_full;
      levels.pressure_window_full = pressure_full;
      return levels;
   endfunction

   function automatic req_type make_scan(input bit ok, input int unsigned battery,
                                         input int unsigned pressure,
                                         input int unsigned current,
                                         input int unsigned voltage);
      req_type scan;
      scan.conversion_ok       = ok;
      scan.battery_sample      = FIELD_W'(battery);
      scan.pressure_sample     = FIELD_W'(pressure);
      scan.pump_current_sample = FIELD_W'(current);
      scan.pump_voltage_sample = FIELD_W'(voltage);
      return scan;
   endfunction

   // samples biased towards the rails so that averages reach both ends
   function automatic int unsigned pick_sample();
      case ($urandom_range(3))
         0: return $urandom_range(1) ? SAMPLE_MAX : 0;
         1: return $urandom_range(SAMPLE_MAX, SAMPLE_MAX - 95);
         default: return $urandom_range(SAMPLE_MAX);
      endcase
   endfunction

   function automatic req_type pick_scan();
      return make_scan($urandom_range(99) < 88, pick_sample(), pick_sample(),
                       pick_sample(), pick_sample());
   endfunction

   task automatic check_field(input string what, input logic [FIELD_W-1:0] want,
                              input logic [FIELD_W-1:0] got);
      if (want != got) begin
         $display("%0t: %s expected %0d, got %0d", $time, what, want, got);
         fail_count++;
      end
   endtask

   // wait until every offered scan has been transferred and answered
   task automatic wait_for_drain();
      while (scan_queue.size() != 0 || req_valid || owed_levels.size() != 0)
         @(posedge clock);
   endtask

   // scan driver: predicts on each transfer and offers the next pending scan
   int unsigned scans_sent = 0;
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall)
            owed_levels.push_back(filter_scan(req_data));
         if (!req_valid || !req_stall) begin
            if (scan_queue.size() != 0 &&
                ((scans_sent >= QUIET_FIRST && scans_sent < QUIET_LAST) ||
                 $urandom_range(99) >= IDLE_PCT)) begin
               req_valid <= 1'b1;
               req_data  <= scan_queue.pop_front();
               scans_sent++;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // level monitor with random stalls and one long backlog
   rsp_type     want_levels;
   int unsigned levels_seen  = 0;
   int unsigned backlog_left = 0;
   bit          backlog_done = 1'b0;
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (owed_levels.size() == 0) begin
               $display("%0t: levels expected none, got %h", $time, rsp_data);
               fail_count++;
            end else begin
               want_levels = owed_levels.pop_front();
               check_field("battery_level", want_levels.battery_level,
                           rsp_data.battery_level);
               check_field("pressure_level", want_levels.pressure_level,
                           rsp_data.pressure_level);
               check_field("pump_current_level", want_levels.pump_current_level,
                           rsp_data.pump_current_level);
               check_field("pump_voltage_level", want_levels.pump_voltage_level,
                           rsp_data.pump_voltage_level);
               check_field("main_window_full", FIELD_W'(want_levels.main_window_full),
                           FIELD_W'(rsp_data.main_window_full));
               check_field("pressure_window_full",
                           FIELD_W'(want_levels.pressure_window_full),
                           FIELD_W'(rsp_data.pressure_window_full));
               check_field("main_just_filled", FIELD_W'(want_levels.main_just_filled),
                           FIELD_W'(rsp_data.main_just_filled));
            end
            levels_seen++;
         end
         if (!backlog_done && levels_seen >= BACKLOG_AT) begin
            backlog_done = 1'b1;
            backlog_left = BACKLOG_LEN;
         end
         if (backlog_left != 0) begin
            backlog_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= !(levels_seen >= QUIET_FIRST && levels_seen < QUIET_LAST) &&
                         $urandom_range(99) < IDLE_PCT;
         end
      end
   end

   // watchdog on cycles with no transfer on either side
   int unsigned stuck_cycles = 0;
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         stuck_cycles <= 0;
      end else begin
         stuck_cycles <= stuck_cycles + 1;
         if (stuck_cycles == STUCK_LIMIT) begin
            $display("tb_multichannel_moving_average_top: FAIL");
            $finish;
         end
      end
   end

   // stimulus
   initial begin
      int unsigned queued;
      int unsigned run_len;
      req_type     held_scan;
      bit          drained_once;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // directed: timed-out scan before any valid one, rails, patterns
      scan_queue.push_back(make_scan(1'b0, SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX));
      scan_queue.push_back(make_scan(1'b1, 0, 0, 0, 0));
      scan_queue.push_back(make_scan(1'b1, SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX));
      scan_queue.push_back(make_scan(1'b0, 0, 0, 0, 0));
      scan_queue.push_back(make_scan(1'b1, 'hAAA, 'h555, 'hAAA, 'h555));
      scan_queue.push_back(make_scan(1'b1, 'h555, 'hAAA, 'h555, 'hAAA));
      scan_queue.push_back(make_scan(1'b1, 1, 2048, 4094, 7));
      scan_queue.push_back(make_scan(1'b0, 'h123, 'h456, 'h789, 'hABC));
      scan_queue.push_back(make_scan(1'b1, 2048, 1, 7, 4094));
      scan_queue.push_back(make_scan(1'b0, SAMPLE_MAX, 0, SAMPLE_MAX, 0));
      wait_for_drain();

      // random: mostly valid scans, with constant runs that push averages to the rails
      queued = 0;
      drained_once = 1'b0;
      while (queued < RANDOM_SCANS) begin
         if ($urandom_range(99) < 8) begin
            run_len = $urandom_range(70, 30);
            case ($urandom_range(2))
               0: held_scan = make_scan(1'b1, SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX,
                                        SAMPLE_MAX);
               1: held_scan = make_scan(1'b1, 0, 0, 0, 0);
               default: held_scan = pick_scan();
            endcase
            held_scan.conversion_ok = 1'b1;
            repeat (run_len) begin
               if ($urandom_range(99) < 5)
                  scan_queue.push_back(pick_scan());
               else
                  scan_queue.push_back(held_scan);
               queued++;
            end
         end else begin
            scan_queue.push_back(pick_scan());
            queued++;
         end
         // sender stands back once until the block has answered everything
         if (!drained_once && queued >= RANDOM_SCANS / 2) begin
            drained_once = 1'b1;
            wait_for_drain();
         end
      end

      wait_for_drain();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0)
         $display("tb_multichannel_moving_average_top: PASS");
      else
         $display("tb_multichannel_moving_average_top: FAIL");
      $finish;
   end

endmodule

`default_nettype wire
